@@ design/cea_pkg.sv @@
// Shared types, codes and saturating arithmetic for the Coulomb and exchange accumulator.
package cea_pkg;

	localparam int IDX_W = 6;
	localparam int SAMPLE_W = 32;
	localparam int ACC_W = 64;
	localparam int FRAC_W = 17;
	localparam logic [FRAC_W-1:0] FRACTION_ONE = 17'd65536;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_INTEG = 2'd1,
		KIND_FOCK  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_ACC,
		ST_FMUL,
		ST_FSUM,
		ST_FSUB,
		ST_OUT
	} state_t;

	typedef struct packed {
		kind_t                      kind;
		logic                       ok;
		logic [IDX_W-1:0]           row;
		logic [IDX_W-1:0]           col;
		logic [IDX_W-1:0]           third;
		logic [IDX_W-1:0]           fourth;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [ACC_W-1:0]    core;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] value;
		logic                    ovf;
	} sat_t;

	function automatic sat_t sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		sat_t r;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		r.ovf = s[ACC_W] != s[ACC_W-1];
		if (r.ovf) begin
			r.value = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r.value = s[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic sat_t sat_sub(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		sat_t r;
		s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
		r.ovf = s[ACC_W] != s[ACC_W-1];
		if (r.ovf) begin
			r.value = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r.value = s[ACC_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ design/cea_front.sv @@
// Front end: accepts requests, checks index ranges and queues them for the back end.
module cea_front #(
	parameter int MATRIX_DIM = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [1:0]                       kind,
	input  logic [cea_pkg::IDX_W-1:0]        row_index,
	input  logic [cea_pkg::IDX_W-1:0]        col_index,
	input  logic [cea_pkg::IDX_W-1:0]        third_index,
	input  logic [cea_pkg::IDX_W-1:0]        fourth_index,
	input  logic signed [cea_pkg::SAMPLE_W-1:0] sample_value,
	input  logic signed [cea_pkg::ACC_W-1:0] core_value,
	output logic                             q_valid,
	input  logic                             q_ready,
	output cea_pkg::item_t                   q_item
);
	import cea_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      item_in;
	logic       rc_ok;
	logic       ls_ok;
	logic       push;
	logic       pop;

	always_comb begin
		rc_ok = (32'(row_index) < MATRIX_DIM) && (32'(col_index) < MATRIX_DIM);
		ls_ok = (32'(third_index) < MATRIX_DIM) && (32'(fourth_index) < MATRIX_DIM);
		item_in.kind = kind_t'(kind);
		item_in.ok = rc_ok && (kind_t'(kind) != KIND_INTEG || ls_ok);
		item_in.row = row_index;
		item_in.col = col_index;
		item_in.third = third_index;
		item_in.fourth = fourth_index;
		item_in.sample = sample_value;
		item_in.core = core_value;
	end

	assign req_ready = count_q != 2'd2;
	assign push = req_valid && req_ready;
	assign q_valid = count_q != 2'd0;
	assign pop = q_valid && q_ready;
	assign q_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ design/cea_back.sv @@
// Back end: density, Coulomb and exchange stores, accumulation and Fock element output.
module cea_back #(
	parameter int MATRIX_DIM = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [cea_pkg::FRAC_W-1:0]       cfg_write_data,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  cea_pkg::item_t                   q_item,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic signed [cea_pkg::ACC_W-1:0] fock_value,
	output logic                             saturated
);
	import cea_pkg::*;

	localparam int DEPTH = MATRIX_DIM * MATRIX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic signed [SAMPLE_W-1:0] dens_mem [DEPTH];
	logic signed [ACC_W-1:0]    j_mem [DEPTH];
	logic signed [ACC_W-1:0]    k_mem [DEPTH];

	state_t state_q, state_d;
	item_t  item_q;
	logic [AW-1:0] clr_cnt_q;
	logic [FRAC_W-1:0] frac_q;
	logic overflow_q;

	logic [AW-1:0] addr_rc, addr_rl, addr_ls, addr_cs, k_raddr;
	logic signed [SAMPLE_W-1:0] dj_rd_q, dk_rd_q;
	logic signed [ACC_W-1:0] j_rd_q, k_rd_q;

	logic signed [ACC_W-1:0] pj_s2, pk_s2;
	logic signed [ACC_W-1:0] jv_s2, t_s3, scaled_s3, fock_s4;
	logic signed [49:0] mhi_s2;
	logic [48:0] mlo_s2;

	logic [FRAC_W-1:0] frac_eff;
	logic signed [ACC_W-1:0] kv, jv;
	logic [81:0] scaled_full;
	sat_t j_sum, k_sum, t_sum, f_diff;

	logic j_we, k_we, d_we;
	logic [AW-1:0] j_waddr, k_waddr;
	logic signed [ACC_W-1:0] j_wdata, k_wdata;
	logic rsp_valid_q;
	logic signed [ACC_W-1:0] rsp_value_q;
	logic rsp_sat_q;

	always_comb begin
		addr_rc = AW'(32'(item_q.row) * MATRIX_DIM + 32'(item_q.col));
		addr_rl = AW'(32'(item_q.row) * MATRIX_DIM + 32'(item_q.third));
		addr_ls = AW'(32'(item_q.third) * MATRIX_DIM + 32'(item_q.fourth));
		addr_cs = AW'(32'(item_q.col) * MATRIX_DIM + 32'(item_q.fourth));
		k_raddr = (item_q.kind == KIND_INTEG) ? addr_rl : addr_rc;
	end

	always_ff @(posedge clk) begin
		dj_rd_q <= dens_mem[addr_ls];
		dk_rd_q <= dens_mem[addr_cs];
		j_rd_q <= j_mem[addr_rc];
		k_rd_q <= k_mem[k_raddr];
		if (d_we) begin
			dens_mem[addr_rc] <= item_q.sample;
		end
		if (j_we) begin
			j_mem[j_waddr] <= j_wdata;
		end
		if (k_we) begin
			k_mem[k_waddr] <= k_wdata;
		end
	end

	always_comb begin
		frac_eff = (frac_q > FRACTION_ONE) ? FRACTION_ONE : frac_q;
		jv = item_q.ok ? j_rd_q : '0;
		kv = item_q.ok ? k_rd_q : '0;
		j_sum = sat_add(j_rd_q, pj_s2 >>> 12);
		k_sum = sat_add(k_rd_q, pk_s2 >>> 12);
		scaled_full = {mhi_s2, 32'b0} + {33'b0, mlo_s2};
		t_sum = sat_add(item_q.core, jv_s2);
		f_diff = sat_sub(t_s3, scaled_s3);
	end

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		d_we = 1'b0;
		j_we = 1'b0;
		k_we = 1'b0;
		j_waddr = addr_rc;
		k_waddr = addr_rl;
		j_wdata = j_sum.value;
		k_wdata = k_sum.value;
		case (state_q)
			ST_CLEAR: begin
				j_we = 1'b1;
				k_we = 1'b1;
				j_waddr = clr_cnt_q;
				k_waddr = clr_cnt_q;
				j_wdata = '0;
				k_wdata = '0;
				if (clr_cnt_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				case (item_q.kind)
					KIND_LOAD: begin
						d_we = item_q.ok;
						state_d = ST_IDLE;
					end
					KIND_INTEG: state_d = item_q.ok ? ST_MUL : ST_IDLE;
					KIND_FOCK: state_d = ST_FMUL;
					KIND_CLEAR: state_d = ST_CLEAR;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				j_we = 1'b1;
				k_we = 1'b1;
				state_d = ST_IDLE;
			end
			ST_FMUL: state_d = ST_FSUM;
			ST_FSUM: state_d = ST_FSUB;
			ST_FSUB: state_d = ST_OUT;
			ST_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			item_q <= q_item;
		end
		if (state_q == ST_MUL) begin
			pj_s2 <= item_q.sample * dj_rd_q;
			pk_s2 <= item_q.sample * dk_rd_q;
		end
		if (state_q == ST_FMUL) begin
			jv_s2 <= jv;
			mhi_s2 <= $signed({1'b0, frac_eff}) * $signed(kv[ACC_W-1:32]);
			mlo_s2 <= frac_eff * kv[31:0];
		end
		if (state_q == ST_FSUM) begin
			t_s3 <= t_sum.value;
			scaled_s3 <= scaled_full[79:16];
		end
		if (state_q == ST_FSUB) begin
			fock_s4 <= f_diff.value;
		end
		if (state_q == ST_OUT && (!rsp_valid_q || rsp_ready)) begin
			rsp_value_q <= fock_s4;
			rsp_sat_q <= overflow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			frac_q <= FRACTION_ONE;
			overflow_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end else begin
				clr_cnt_q <= '0;
			end
			if (cfg_write_en) begin
				frac_q <= cfg_write_data;
			end
			if ((state_q == ST_ACC && (j_sum.ovf || k_sum.ovf))
					|| (state_q == ST_FSUM && t_sum.ovf)
					|| (state_q == ST_FSUB && f_diff.ovf)) begin
				overflow_q <= 1'b1;
			end
			if (state_q == ST_OUT && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign fock_value = rsp_value_q;
	assign saturated = rsp_sat_q;

endmodule

@@ design/coulomb_exchange_accumulator.sv @@
// Top level of the Coulomb and exchange accumulator for a fixed-point Fock matrix build.
//
//   Channel   Signals                                  Direction
//   request   req_valid, req_ready, kind .. core_value  in
//   response  rsp_valid, rsp_ready, fock_value, saturated out
//   config    cfg_write_en, cfg_write_data             in
//
// Requests are handled one at a time: a density load uses READ, an integral READ, MUL and ACC,
// a Fock read READ, FMUL, FSUM, FSUB and OUT, which waits out any response stall.
// A clear request zeroes both accumulator stores, all MATRIX_DIM squared entries, one a cycle.
// The same sweep runs after reset, and no request leaves the queue until it ends.
// A two-entry queue lets requests arrive while the back end or the response side stalls.
module coulomb_exchange_accumulator #(
	parameter int MATRIX_DIM = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [cea_pkg::FRAC_W-1:0]       cfg_write_data,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [1:0]                       kind,
	input  logic [cea_pkg::IDX_W-1:0]        row_index,
	input  logic [cea_pkg::IDX_W-1:0]        col_index,
	input  logic [cea_pkg::IDX_W-1:0]        third_index,
	input  logic [cea_pkg::IDX_W-1:0]        fourth_index,
	input  logic signed [cea_pkg::SAMPLE_W-1:0] sample_value,
	input  logic signed [cea_pkg::ACC_W-1:0] core_value,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic signed [cea_pkg::ACC_W-1:0] fock_value,
	output logic                             saturated
);
	import cea_pkg::*;

	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	cea_front #(.MATRIX_DIM(MATRIX_DIM)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.kind(kind),
		.row_index(row_index),
		.col_index(col_index),
		.third_index(third_index),
		.fourth_index(fourth_index),
		.sample_value(sample_value),
		.core_value(core_value),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item)
	);

	cea_back #(.MATRIX_DIM(MATRIX_DIM)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.fock_value(fock_value),
		.saturated(saturated)
	);

endmodule
